// ===== rtl/core/mbtcp_pkg.sv =====
// ----------------------------------------------------------------------------
// mbtcp_pkg
// Shared types and constants for the Modbus TCP request checker: function
// codes, exception status codes, register indexes and the result record.
// ----------------------------------------------------------------------------
package mbtcp_pkg;

   // configuration register indexes
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;

   localparam logic [CsrIdxW-1:0] CSR_COIL_SPACE          = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_DISCRETE_SPACE      = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_INPUT_REG_SPACE     = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_HOLDING_REG_SPACE   = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_READ_COILS_LIMIT    = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_READ_DISCRETE_LIMIT = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_READ_REGS_LIMIT     = 3'd6;
   localparam logic [CsrIdxW-1:0] CSR_WRITE_REGS_LIMIT    = 3'd7;

   // register reset values and the fixed write-coils limit
   localparam logic [15:0] SPACE_RESET          = 16'd65535;
   localparam logic [15:0] READ_BITS_RESET      = 16'd2000;
   localparam logic [15:0] READ_REGS_RESET      = 16'd125;
   localparam logic [15:0] WRITE_REGS_RESET     = 16'd123;
   localparam logic [15:0] WRITE_COILS_LIMIT    = 16'd1968;

   // function codes
   localparam logic [7:0] FC_READ_COILS     = 8'd1;
   localparam logic [7:0] FC_READ_DISCRETE  = 8'd2;
   localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
   localparam logic [7:0] FC_READ_INPUT     = 8'd4;
   localparam logic [7:0] FC_WRITE_COIL     = 8'd5;
   localparam logic [7:0] FC_WRITE_REG      = 8'd6;
   localparam logic [7:0] FC_WRITE_COILS    = 8'd15;
   localparam logic [7:0] FC_WRITE_REGS     = 8'd16;

   // exception status
   localparam logic [1:0] ST_ACCEPTED        = 2'd0;
   localparam logic [1:0] ST_ILLEGAL_FUNCTION = 2'd1;
   localparam logic [1:0] ST_ILLEGAL_ADDRESS = 2'd2;
   localparam logic [1:0] ST_ILLEGAL_VALUE   = 2'd3;

   // result kinds
   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // result queue
   localparam int RspDepth = 4;
   localparam int RspPtrW  = $clog2(RspDepth);
   localparam int RspCntW  = $clog2(RspDepth + 1);

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [7:0]  data_index;
      logic [15:0] txn_ident;
      logic [7:0]  unit_id;
      logic [7:0]  func_num;
      logic [15:0] start_address;
      logic [15:0] quantity;
      logic [7:0]  payload_len;
      logic        parse_ok;
      logic [1:0]  status;
   } rsp_type;

   function automatic logic is_single(input logic [7:0] f);
      return (f == FC_WRITE_COIL) || (f == FC_WRITE_REG);
   endfunction

   function automatic logic is_multi(input logic [7:0] f);
      return (f == FC_WRITE_COILS) || (f == FC_WRITE_REGS);
   endfunction

   function automatic logic is_read(input logic [7:0] f);
      return (f == FC_READ_COILS) || (f == FC_READ_DISCRETE) ||
             (f == FC_READ_HOLDING) || (f == FC_READ_INPUT);
   endfunction

endpackage

// ===== rtl/core/modbus_tcp_request_checker_unit.sv =====
// each accepted byte is registered, then its results are queued for the result port
// throughput: one byte per cycle through the single check stage while req_stall is low
// a byte giving both a data result and the summary pushes two queue entries
// a four-entry result queue lets the input run on while results wait
// reset: synchronous, active high; clears frame state, loads register defaults
// ----------------------------------------------------------------------------
// modbus_tcp_request_checker_unit
// Captures Modbus TCP request header and function fields byte by byte,
// passes write data bytes out and emits a checked summary at frame end.
// ----------------------------------------------------------------------------
module modbus_tcp_request_checker_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_frame_byte,
   input  logic                           req_frame_end,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_kind,
   output logic [7:0]                     rsp_data_byte,
   output logic [7:0]                     rsp_data_index,
   output logic [15:0]                    rsp_txn_ident,
   output logic [7:0]                     rsp_unit_id,
   output logic [7:0]                     rsp_func_num,
   output logic [15:0]                    rsp_start_address,
   output logic [15:0]                    rsp_quantity,
   output logic [7:0]                     rsp_payload_len,
   output logic                           rsp_parse_ok,
   output logic [1:0]                     rsp_status,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mbtcp_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [mbtcp_pkg::CsrDataW-1:0] csr_data
);
   import mbtcp_pkg::*;

   // configuration
   logic [15:0] coil_space_ff, discrete_space_ff, input_space_ff, holding_space_ff;
   logic [15:0] rd_coils_lim_ff, rd_disc_lim_ff, rd_regs_lim_ff, wr_regs_lim_ff;

   // input register
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff, s1_byte_in;
   logic        s1_end_ff, s1_end_in;
   logic        s1_move;

   // frame state
   logic [15:0] pos_ff, pos_in;
   logic [15:0] txn_ff, txn_in, proto_ff, proto_in, lenf_ff, lenf_in;
   logic [15:0] addr_ff, addr_in, qty_ff, qty_in;
   logic [7:0]  unit_ff, unit_in, func_ff, func_in, count_ff, count_in;

   // captured view including the byte in the input register
   logic [15:0] cap_txn, cap_proto, cap_lenf, cap_addr, cap_qty;
   logic [7:0]  cap_unit, cap_func, cap_count;

   logic        emit;
   logic [15:0] off10, off13;
   logic [7:0]  data_idx;
   logic [15:0] frame_len;
   logic        parse_ok;
   logic [16:0] expect_coils;
   logic [15:0] expect_regs;
   logic        count_match;
   logic [15:0] qty_eff, lim, space;
   logic [16:0] addr_end;
   logic [1:0]  judge_st, status;
   rsp_type     data_rsp, sum_rsp;

   // result queue
   rsp_type              rsp_mem_ff [RspDepth];
   logic [RspPtrW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [RspCntW-1:0]   cnt_ff, cnt_in;
   logic [RspCntW-1:0]   push_n;
   logic                 pop;
   rsp_type              head;

   // configuration port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coil_space_ff     <= SPACE_RESET;
         discrete_space_ff <= SPACE_RESET;
         input_space_ff    <= SPACE_RESET;
         holding_space_ff  <= SPACE_RESET;
         rd_coils_lim_ff   <= READ_BITS_RESET;
         rd_disc_lim_ff    <= READ_BITS_RESET;
         rd_regs_lim_ff    <= READ_REGS_RESET;
         wr_regs_lim_ff    <= WRITE_REGS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COIL_SPACE:          coil_space_ff     <= csr_data;
            CSR_DISCRETE_SPACE:      discrete_space_ff <= csr_data;
            CSR_INPUT_REG_SPACE:     input_space_ff    <= csr_data;
            CSR_HOLDING_REG_SPACE:   holding_space_ff  <= csr_data;
            CSR_READ_COILS_LIMIT:    rd_coils_lim_ff   <= csr_data;
            CSR_READ_DISCRETE_LIMIT: rd_disc_lim_ff    <= csr_data;
            CSR_READ_REGS_LIMIT:     rd_regs_lim_ff    <= csr_data;
            CSR_WRITE_REGS_LIMIT:    wr_regs_lim_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // input handshake
   assign s1_move   = s1_valid_ff && (cnt_ff <= RspCntW'(RspDepth - 2));
   assign req_stall = s1_valid_ff && !s1_move;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_end_in   = s1_end_ff;
      if (!s1_valid_ff || s1_move) begin
         s1_valid_in = req_valid;
         s1_byte_in  = req_frame_byte;
         s1_end_in   = req_frame_end;
      end
   end

   // field capture
   always_comb begin
      cap_txn   = txn_ff;
      cap_proto = proto_ff;
      cap_lenf  = lenf_ff;
      cap_unit  = unit_ff;
      cap_func  = func_ff;
      cap_addr  = addr_ff;
      cap_qty   = qty_ff;
      cap_count = count_ff;
      case (pos_ff)
         16'd0:   cap_txn   = {s1_byte_ff, txn_ff[7:0]};
         16'd1:   cap_txn   = {txn_ff[15:8], s1_byte_ff};
         16'd2:   cap_proto = {s1_byte_ff, proto_ff[7:0]};
         16'd3:   cap_proto = {proto_ff[15:8], s1_byte_ff};
         16'd4:   cap_lenf  = {s1_byte_ff, lenf_ff[7:0]};
         16'd5:   cap_lenf  = {lenf_ff[15:8], s1_byte_ff};
         16'd6:   cap_unit  = s1_byte_ff;
         16'd7:   cap_func  = s1_byte_ff;
         16'd8:   cap_addr  = {s1_byte_ff, addr_ff[7:0]};
         16'd9:   cap_addr  = {addr_ff[15:8], s1_byte_ff};
         16'd10:  cap_qty   = {s1_byte_ff, qty_ff[7:0]};
         16'd11:  cap_qty   = {qty_ff[15:8], s1_byte_ff};
         16'd12:  cap_count = s1_byte_ff;
         default: ;
      endcase
   end

   // write data pass-through
   assign off10 = pos_ff - 16'd10;
   assign off13 = pos_ff - 16'd13;

   always_comb begin
      emit     = 1'b0;
      data_idx = 8'd0;
      if (is_single(func_ff) && (pos_ff == 16'd10 || pos_ff == 16'd11)) begin
         emit     = 1'b1;
         data_idx = off10[7:0];
      end else if (is_multi(func_ff) && pos_ff >= 16'd13 &&
                   off13 < {8'd0, count_ff}) begin
         emit     = 1'b1;
         data_idx = off13[7:0];
      end
   end

   // parse checks
   assign frame_len    = (pos_ff == 16'hFFFF) ? 16'hFFFF : pos_ff + 16'd1;
   assign expect_coils = ({1'b0, cap_qty} + 17'd7) >> 3;
   assign expect_regs  = {cap_qty[14:0], 1'b0};
   assign count_match  = (cap_func == FC_WRITE_COILS) ?
                         (expect_coils == {9'd0, cap_count}) :
                         (expect_regs == {8'd0, cap_count});

   always_comb begin
      parse_ok = 1'b0;
      if (frame_len >= 16'd9 && cap_proto == 16'd0 && cap_lenf >= 16'd2 &&
          cap_lenf <= frame_len - 16'd6) begin
         if (is_read(cap_func) || is_single(cap_func)) begin
            parse_ok = (frame_len >= 16'd12);
         end else if (is_multi(cap_func)) begin
            parse_ok = (frame_len >= 16'd13) && count_match &&
                       ({1'b0, frame_len} >= 17'd13 + {9'd0, cap_count});
         end
      end
   end

   // exception judgement
   assign qty_eff  = is_single(cap_func) ? 16'd1 : cap_qty;
   assign addr_end = {1'b0, cap_addr} + {1'b0, qty_eff};

   always_comb begin
      case (cap_func)
         FC_READ_COILS: begin
            lim   = rd_coils_lim_ff;
            space = coil_space_ff;
         end
         FC_READ_DISCRETE: begin
            lim   = rd_disc_lim_ff;
            space = discrete_space_ff;
         end
         FC_READ_HOLDING: begin
            lim   = rd_regs_lim_ff;
            space = holding_space_ff;
         end
         FC_READ_INPUT: begin
            lim   = rd_regs_lim_ff;
            space = input_space_ff;
         end
         FC_WRITE_COIL: begin
            lim   = 16'd1;
            space = coil_space_ff;
         end
         FC_WRITE_REG: begin
            lim   = 16'd1;
            space = holding_space_ff;
         end
         FC_WRITE_COILS: begin
            lim   = WRITE_COILS_LIMIT;
            space = coil_space_ff;
         end
         default: begin
            lim   = wr_regs_lim_ff;
            space = holding_space_ff;
         end
      endcase
   end

   always_comb begin
      if (qty_eff == 16'd0 || qty_eff > lim) begin
         judge_st = ST_ILLEGAL_VALUE;
      end else if (cap_addr >= space || addr_end > {1'b0, space}) begin
         judge_st = ST_ILLEGAL_ADDRESS;
      end else begin
         judge_st = ST_ACCEPTED;
      end
   end

   assign status = parse_ok ? judge_st : ST_ILLEGAL_FUNCTION;

   // result records
   always_comb begin
      data_rsp            = '0;
      data_rsp.kind       = KIND_DATA;
      data_rsp.data_byte  = s1_byte_ff;
      data_rsp.data_index = data_idx;

      sum_rsp               = '0;
      sum_rsp.kind          = KIND_SUMMARY;
      sum_rsp.txn_ident     = cap_txn;
      sum_rsp.unit_id       = cap_unit;
      sum_rsp.func_num      = (frame_len < 16'd9) ? 8'd0 : cap_func;
      sum_rsp.start_address = cap_addr;
      sum_rsp.quantity      = qty_eff;
      sum_rsp.payload_len   = is_multi(cap_func) ? cap_count : 8'd0;
      sum_rsp.parse_ok      = parse_ok;
      sum_rsp.status        = status;
   end

   // frame state update
   always_comb begin
      pos_in   = pos_ff;
      txn_in   = txn_ff;
      proto_in = proto_ff;
      lenf_in  = lenf_ff;
      unit_in  = unit_ff;
      func_in  = func_ff;
      addr_in  = addr_ff;
      qty_in   = qty_ff;
      count_in = count_ff;
      if (s1_move) begin
         if (s1_end_ff) begin
            pos_in   = '0;
            txn_in   = '0;
            proto_in = '0;
            lenf_in  = '0;
            unit_in  = '0;
            func_in  = '0;
            addr_in  = '0;
            qty_in   = '0;
            count_in = '0;
         end else begin
            pos_in   = frame_len;
            txn_in   = cap_txn;
            proto_in = cap_proto;
            lenf_in  = cap_lenf;
            unit_in  = cap_unit;
            func_in  = cap_func;
            addr_in  = cap_addr;
            qty_in   = cap_qty;
            count_in = cap_count;
         end
      end
   end

   // result queue control
   assign pop    = (cnt_ff != '0) && !rsp_stall;
   assign push_n = s1_move ? (RspCntW'(emit) + RspCntW'(s1_end_ff)) : '0;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_n[RspPtrW-1:0];
      rd_ptr_in = pop ? rd_ptr_ff + RspPtrW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + push_n - RspCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         if (emit) begin
            rsp_mem_ff[wr_ptr_ff] <= data_rsp;
            if (s1_end_ff) begin
               rsp_mem_ff[wr_ptr_ff + RspPtrW'(1)] <= sum_rsp;
            end
         end else if (s1_end_ff) begin
            rsp_mem_ff[wr_ptr_ff] <= sum_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      s1_end_ff  <= s1_end_in;
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         cnt_ff      <= '0;
         pos_ff      <= '0;
         txn_ff      <= '0;
         proto_ff    <= '0;
         lenf_ff     <= '0;
         unit_ff     <= '0;
         func_ff     <= '0;
         addr_ff     <= '0;
         qty_ff      <= '0;
         count_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         cnt_ff      <= cnt_in;
         pos_ff      <= pos_in;
         txn_ff      <= txn_in;
         proto_ff    <= proto_in;
         lenf_ff     <= lenf_in;
         unit_ff     <= unit_in;
         func_ff     <= func_in;
         addr_ff     <= addr_in;
         qty_ff      <= qty_in;
         count_ff    <= count_in;
      end
   end

   // result port
   assign head              = rsp_mem_ff[rd_ptr_ff];
   assign rsp_valid         = (cnt_ff != '0);
   assign rsp_kind          = head.kind;
   assign rsp_data_byte     = head.data_byte;
   assign rsp_data_index    = head.data_index;
   assign rsp_txn_ident     = head.txn_ident;
   assign rsp_unit_id       = head.unit_id;
   assign rsp_func_num      = head.func_num;
   assign rsp_start_address = head.start_address;
   assign rsp_quantity      = head.quantity;
   assign rsp_payload_len   = head.payload_len;
   assign rsp_parse_ok      = head.parse_ok;
   assign rsp_status        = head.status;

endmodule
